### src/spr_pkg.sv
// ----------------------------------------------------------------------------
// Stream pattern replace package
// Shared widths, configuration register codes and the structs that travel
// between the intake, the queue and the rewrite engine.
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 64;
   localparam int LEN_W       = 4;
   localparam int SLOT_W      = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              end_of_text;
   } item_type;

   typedef struct packed {
      logic [WORD_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]  pattern_length;
      logic [WORD_W-1:0] replacement_bytes;
      logic [LEN_W-1:0]  replacement_length;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### src/spr_if.sv
// ----------------------------------------------------------------------------
// Stream pattern replace channels
// Valid/ready channels for text requests and rewritten results.
// ----------------------------------------------------------------------------
interface spr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface spr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       last_out;

   modport source (output valid, output out_byte, output has_byte, output last_out,
                   input ready);
   modport sink (input valid, input out_byte, input has_byte, input last_out,
                 output ready);
endinterface

### src/stream_pattern_replace_top.sv
// ----------------------------------------------------------------------------
// Stream pattern replace
// Streaming find-and-replace on a byte stream with a lookahead window.
//
//   Channel  Direction  Carries
//   req      in         text_byte, end_of_text
//   rsp      out        out_byte, has_byte, last_out
//   csr      in         csr_we, csr_index, csr_wdata
//
// A request that decides no position only enters the window.
// A request that decides positions enters the window, and then the engine
// passes bytes, emits replacement bytes or drops a match with an empty replacement.
// A final request also brings out the end mark.
// Reset clears the configuration, the queue and the window fill.
// A stalled rsp holds the engine; the two-entry queue lets req take bytes until it is full.
// ----------------------------------------------------------------------------
module stream_pattern_replace_top #(
   parameter int PAT_MAX = 8,
   parameter int REP_MAX = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  spr_pkg::csr_index_type     csr_index,
   input  logic [spr_pkg::WORD_W-1:0] csr_wdata,
   spr_req_if.sink                    req,
   spr_rsp_if.source                  rsp
);
   import spr_pkg::*;

   queue_status_type q_status;
   logic             push_valid;
   item_type         push_item;
   cfg_type          cfg;
   logic             q_valid;
   item_type         q_item;
   logic             pop;

   spr_front #(
      .PAT_MAX (PAT_MAX),
      .REP_MAX (REP_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req        (req),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_item  (push_item),
      .cfg        (cfg)
   );

   spr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_status   (q_status)
   );

   spr_back #(
      .PAT_MAX (PAT_MAX)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_item  (q_item),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule

### src/spr_front.sv
// ----------------------------------------------------------------------------
// Stream pattern replace intake
// Holds the configuration registers, clamps the lengths and hands each
// accepted request to the queue.
// ----------------------------------------------------------------------------
module spr_front #(
   parameter int PAT_MAX = 8,
   parameter int REP_MAX = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  spr_pkg::csr_index_type    csr_index,
   input  logic [spr_pkg::WORD_W-1:0] csr_wdata,
   spr_req_if.sink                   req,
   input  spr_pkg::queue_status_type q_status,
   output logic                      push_valid,
   output spr_pkg::item_type         push_item,
   output spr_pkg::cfg_type          cfg
);
   import spr_pkg::*;

   logic [WORD_W-1:0] pattern_bytes_ff, pattern_bytes_in;
   logic [LEN_W-1:0]  pattern_length_ff, pattern_length_in;
   logic [WORD_W-1:0] replacement_bytes_ff, replacement_bytes_in;
   logic [LEN_W-1:0]  replacement_length_ff, replacement_length_in;

   always_comb begin
      pattern_bytes_in      = pattern_bytes_ff;
      pattern_length_in     = pattern_length_ff;
      replacement_bytes_in  = replacement_bytes_ff;
      replacement_length_in = replacement_length_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:      pattern_bytes_in = csr_wdata;
            CSR_PATTERN_LENGTH:     pattern_length_in = csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  replacement_bytes_in = csr_wdata;
            CSR_REPLACEMENT_LENGTH: replacement_length_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= '0;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else begin
         pattern_bytes_ff      <= pattern_bytes_in;
         pattern_length_ff     <= pattern_length_in;
         replacement_bytes_ff  <= replacement_bytes_in;
         replacement_length_ff <= replacement_length_in;
      end
   end

   // Lengths beyond the supported sizes are clamped.
   always_comb begin
      cfg.pattern_bytes     = pattern_bytes_ff;
      cfg.replacement_bytes = replacement_bytes_ff;
      cfg.pattern_length    = (pattern_length_ff > LEN_W'(PAT_MAX)) ?
                              LEN_W'(PAT_MAX) : pattern_length_ff;
      cfg.replacement_length = (replacement_length_ff > LEN_W'(REP_MAX)) ?
                               LEN_W'(REP_MAX) : replacement_length_ff;
   end

   assign req.ready             = !q_status.full;
   assign push_valid            = req.valid && !q_status.full;
   assign push_item.text_byte   = req.text_byte;
   assign push_item.end_of_text = req.end_of_text;

endmodule

### src/spr_queue.sv
// ----------------------------------------------------------------------------
// Stream pattern replace request queue
// Short FIFO that decouples the intake from the rewrite engine.
// ----------------------------------------------------------------------------
module spr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  spr_pkg::item_type         push_item,
   input  logic                      pop,
   output logic                      q_valid,
   output spr_pkg::item_type         q_item,
   output spr_pkg::queue_status_type q_status
);
   import spr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_valid        = !q_status.empty;
   assign q_item         = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### src/spr_back.sv
// ----------------------------------------------------------------------------
// Stream pattern replace engine
// Keeps the lookahead window, decides one position at a time, emits the
// replacement one byte per cycle unless rsp stalls, and marks the text end.
// ----------------------------------------------------------------------------
module spr_back #(
   parameter int PAT_MAX = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  spr_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  spr_pkg::item_type q_item,
   output logic              pop,
   spr_rsp_if.source         rsp
);
   import spr_pkg::*;

   localparam int FILL_W = $clog2(PAT_MAX + 1);

   logic [BYTE_W-1:0] window_ff [PAT_MAX];
   logic [BYTE_W-1:0] window_in [PAT_MAX];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              active_ff, active_in;
   logic              final_ff, final_in;
   logic [SLOT_W-1:0] rep_idx_ff, rep_idx_in;
   logic              hold_v_ff, hold_v_in;
   logic [BYTE_W-1:0] hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_has_ff, rsp_has_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic [LEN_W-1:0]  thr;
   logic [LEN_W-1:0]  fill_ext;
   logic [LEN_W-1:0]  fill_next_ext;
   logic [LEN_W-1:0]  fill_after;
   logic              pending;
   logic              mismatch;
   logic              match;
   logic              emit;
   logic [BYTE_W-1:0] emit_byte;
   logic              drop;
   logic [LEN_W-1:0]  drop_n;
   logic [BYTE_W-1:0] rep_byte;

   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign thr           = (cfg.pattern_length == '0) ? LEN_W'(1) : cfg.pattern_length;
   assign fill_ext      = LEN_W'(fill_ff);
   assign fill_next_ext = LEN_W'(fill_ff + 1'b1);
   assign fill_after    = fill_ext - drop_n;
   assign pending       = final_ff ? (fill_ff != '0) : (fill_ext >= thr);
   assign rep_byte      = cfg.replacement_bytes[{rep_idx_ff, 3'b000} +: BYTE_W];

   always_comb begin
      mismatch = 1'b0;
      for (int j = 0; j < PAT_MAX; j++) begin
         if ((LEN_W'(j) < cfg.pattern_length) &&
             (window_ff[j] != cfg.pattern_bytes[j*BYTE_W +: BYTE_W])) begin
            mismatch = 1'b1;
         end
      end
      match = (cfg.pattern_length != '0) && (fill_ext >= cfg.pattern_length) && !mismatch;
   end

   always_comb begin
      active_in  = active_ff;
      final_in   = final_ff;
      rep_idx_in = rep_idx_ff;
      pop        = 1'b0;
      emit       = 1'b0;
      emit_byte  = window_ff[0];
      drop       = 1'b0;
      drop_n     = LEN_W'(1);
      if (!active_ff) begin
         if (q_valid) begin
            pop       = 1'b1;
            final_in  = q_item.end_of_text;
            active_in = q_item.end_of_text || (fill_next_ext >= thr);
         end
      end else if (out_free) begin
         if (pending) begin
            if (match) begin
               drop_n = cfg.pattern_length;
               if (cfg.replacement_length == '0) begin
                  drop = 1'b1;
               end else begin
                  emit      = 1'b1;
                  emit_byte = rep_byte;
                  if (LEN_W'(rep_idx_ff) + LEN_W'(1) == cfg.replacement_length) begin
                     rep_idx_in = '0;
                     drop       = 1'b1;
                  end else begin
                     rep_idx_in = SLOT_W'(rep_idx_ff + 1'b1);
                  end
               end
            end else begin
               emit = 1'b1;
               drop = 1'b1;
            end
            if (drop && !final_ff && (fill_after < thr)) begin
               active_in = 1'b0;
            end
         end else if (final_ff) begin
            active_in = 1'b0;
            final_in  = 1'b0;
         end else begin
            active_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < PAT_MAX; i++) begin
         window_in[i] = window_ff[i];
      end
      fill_in = fill_ff;
      if (pop && (fill_ext < LEN_W'(PAT_MAX))) begin
         for (int j = 0; j < PAT_MAX; j++) begin
            if (FILL_W'(j) == fill_ff) begin
               window_in[j] = q_item.text_byte;
            end
         end
         fill_in = FILL_W'(fill_ff + 1'b1);
      end else if (drop) begin
         for (int i = 0; i < PAT_MAX; i++) begin
            for (int s = 1; s < PAT_MAX - i; s++) begin
               if (drop_n == LEN_W'(s)) begin
                  window_in[i] = window_ff[i+s];
               end
            end
         end
         fill_in = FILL_W'(fill_after);
      end
   end

   // While the final request is flushed, one byte is held back so that the
   // last one can carry the end mark.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      hold_v_in    = hold_v_ff;
      hold_in      = hold_ff;
      if (emit) begin
         if (final_ff) begin
            hold_v_in = 1'b1;
            hold_in   = emit_byte;
            if (hold_v_ff) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hold_ff;
               rsp_has_in   = 1'b1;
               rsp_last_in  = 1'b0;
            end
         end else begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = emit_byte;
            rsp_has_in   = 1'b1;
            rsp_last_in  = 1'b0;
         end
      end else if (active_ff && out_free && final_ff && !pending) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = hold_v_ff ? hold_ff : '0;
         rsp_has_in   = hold_v_ff;
         rsp_last_in  = 1'b1;
         hold_v_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         active_ff    <= 1'b0;
         final_ff     <= 1'b0;
         rep_idx_ff   <= '0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         active_ff    <= active_in;
         final_ff     <= final_in;
         rep_idx_ff   <= rep_idx_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PAT_MAX; i++) begin
         window_ff[i] <= window_in[i];
      end
      hold_ff     <= hold_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.has_byte = rsp_has_ff;
   assign rsp.last_out = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(fill_ff) <= LEN_W'(PAT_MAX))
      else $error("lookahead window overfilled");

   a_hold_in_flush: assert property (@(posedge clock) disable iff (reset)
      hold_v_ff |-> (active_ff && final_ff))
      else $error("held byte outside of a flush");

   a_rep_active: assert property (@(posedge clock) disable iff (reset)
      (rep_idx_ff != '0) |-> (active_ff && match))
      else $error("replacement burst without a pending match");

   a_no_pop_while_active: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !pop)
      else $error("request taken while a previous one is in work");

endmodule
